// ----- hdl/cac_pkg.sv -----
// Shared types, constants and helpers for the color adjust chain.
package cac_pkg;

  localparam int CH_W      = 8;
  localparam int CH_N      = 3;
  localparam int BRIGHT_W  = 9;
  localparam int LEVEL_W   = 8;
  localparam int TEMP_W    = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SAT_W     = 14;

  // Channel positions inside a beat.
  localparam int RED = 0;
  localparam int GRN = 1;
  localparam int BLU = 2;

  // Constant bias that the temperature stage adds to green and blue.
  localparam int TEMP_BIAS = 10;

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
  } in_pix_t;

  typedef struct packed {
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
  } out_pix_t;

  // One pipeline beat: a valid bit and the three channels.
  typedef struct packed {
    logic                       valid;
    logic [CH_N-1:0][CH_W-1:0]  ch;
  } beat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHT   = 2'd0,
    CFG_CONTRAST = 2'd1,
    CFG_TEMP     = 2'd2
  } cfg_idx_t;

  // Limits a signed intermediate value to the channel range 0..255.
  function automatic chan_t sat_chan(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] top;
    top = SAT_W'((1 << CH_W) - 1);
    if (v < 0) begin
      return '0;
    end else if (v > top) begin
      return '1;
    end
    return v[CH_W-1:0];
  endfunction

endpackage

// ----- hdl/color_adjust_chain.sv -----
// Top level of the color adjust chain: settings registers and the pixel pipeline.
//
// This block takes one RGB pixel request per clock and returns one adjusted pixel
// per request, in request order, after the brightness stage, the contrast steps
// (gain-square multiply, mid-grey offset and range check, reciprocal multiply for
// the divide by 20000) and the temperature steps (numerator build, then
// reciprocal divide and clamp). A request is taken at every rising edge where start
// is high and busy is low; busy is high only while reset is asserted, so a full
// stream of one pixel per clock is sustained. Each result appears for exactly one
// cycle with out_strobe high and cannot be held off, so the receiver must take it
// in that cycle. Settings are written through cfg_we, cfg_index and cfg_data and
// should only change while no pixel is in flight; an index beyond the three
// registers is ignored. Data that is wider than a register is cut to its width and
// read as two's complement.
module color_adjust_chain (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  cac_pkg::in_pix_t                  in_pix,
  output logic                              out_strobe,
  output cac_pkg::out_pix_t                 out_pix,
  input  logic                              cfg_we,
  input  logic [cac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cac_pkg::CFG_W-1:0]         cfg_data
);

  // Settings registers, all reset to zero.
  logic signed [cac_pkg::BRIGHT_W-1:0] bright_r;
  logic signed [cac_pkg::LEVEL_W-1:0]  contrast_r;
  logic signed [cac_pkg::TEMP_W-1:0]   temp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r   <= '0;
      contrast_r <= '0;
      temp_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cac_pkg::CFG_BRIGHT:   bright_r   <= cfg_data[cac_pkg::BRIGHT_W-1:0];
        cac_pkg::CFG_CONTRAST: contrast_r <= cfg_data[cac_pkg::LEVEL_W-1:0];
        cac_pkg::CFG_TEMP:     temp_r     <= cfg_data[cac_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so requests are refused only during reset.
  assign busy = ~rst_n;

  cac_pkg::beat_t beat_in;
  cac_pkg::beat_t beat_br;
  cac_pkg::beat_t beat_ct;

  assign beat_in.valid            = start & ~busy;
  assign beat_in.ch[cac_pkg::RED] = in_pix.red_in;
  assign beat_in.ch[cac_pkg::GRN] = in_pix.green_in;
  assign beat_in.ch[cac_pkg::BLU] = in_pix.blue_in;

  cac_bright u_bright (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_i   (beat_in),
    .offset_i (bright_r),
    .beat_o   (beat_br)
  );

  cac_contrast u_contrast (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_i  (beat_br),
    .level_i (contrast_r),
    .beat_o  (beat_ct)
  );

  cac_temper u_temper (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_i  (beat_ct),
    .shift_i (temp_r),
    .valid_o (out_strobe),
    .pix_o   (out_pix)
  );

  // Every accepted request leaves the pipeline as a result strobe, and nothing else does.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == $past(start && !busy, 6))
    else $error("result strobe does not match request six cycles earlier");

  // The temperature stage always adds a positive bias to blue.
  a_blue_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_pix.blue_out >= 8'd2))
    else $error("blue result below the temperature bias floor");

  // With a warm or neutral setting, green and blue gain at least the full bias.
  a_warm_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !temp_r[cac_pkg::TEMP_W-1]) |->
      (out_pix.green_out >= 8'(cac_pkg::TEMP_BIAS) &&
       out_pix.blue_out >= 8'(cac_pkg::TEMP_BIAS)))
    else $error("warm setting result below the temperature bias");

endmodule

// ----- hdl/cac_bright.sv -----
// Brightness stage: adds the signed offset to each channel and clamps.
module cac_bright (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cac_pkg::beat_t                        beat_i,
  input  logic signed [cac_pkg::BRIGHT_W-1:0]   offset_i,
  output cac_pkg::beat_t                        beat_o
);

  localparam int SW = cac_pkg::SAT_W;
  localparam int CW = cac_pkg::CH_W;

  logic                                          valid_r;
  logic [cac_pkg::CH_N-1:0][cac_pkg::CH_W-1:0]   ch_r;
  logic [cac_pkg::CH_N-1:0][cac_pkg::CH_W-1:0]   ch_nxt;

  always_comb begin
    for (int i = 0; i < cac_pkg::CH_N; i++) begin
      ch_nxt[i] = cac_pkg::sat_chan($signed({{(SW-CW){1'b0}}, beat_i.ch[i]}) + SW'(offset_i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= beat_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
  end

  assign beat_o.valid = valid_r;
  assign beat_o.ch    = ch_r;

endmodule

// ----- hdl/cac_contrast.sv -----
// Contrast stage: three pipeline steps of (2v-255)*k^2 + 2550000, then /20000.
module cac_contrast (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cac_pkg::beat_t                        beat_i,
  input  logic signed [cac_pkg::LEVEL_W-1:0]    level_i,
  output cac_pkg::beat_t                        beat_o
);

  localparam int N  = cac_pkg::CH_N;
  localparam int CW = cac_pkg::CH_W;
  localparam int PW = 27;              // product and offset sum width
  localparam int MW = 18;              // numerator after dropping the five low bits
  localparam int RW = 19;              // reciprocal width
  localparam int DSHIFT = 28;          // 2^28/625 reciprocal, exact for numerators < 2^18
  localparam logic [RW-1:0] DRECIP = RW'(429497);
  localparam logic signed [PW-1:0] MID_N = PW'(2550000);
  localparam logic signed [PW-1:0] SAT_N = PW'(5100000);
  localparam logic [15:0] K2_RESET = 16'd10000;

  // Gain square, derived from the level register.
  logic signed [8:0]  k;
  logic signed [17:0] kk;
  logic [15:0]        k2_r;

  assign k  = 9'sd100 + 9'(level_i);
  assign kk = k * k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k2_r <= K2_RESET;
    end else begin
      k2_r <= kk[15:0];
    end
  end

  // Step A: signed product.
  logic                 va_r;
  logic signed [PW-1:0] pa_r   [N];
  logic signed [PW-1:0] pa_nxt [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      pa_nxt[i] = ($signed({1'b0, beat_i.ch[i], 1'b0}) - 10'sd255) * $signed({1'b0, k2_r});
    end
  end

  // Step B: add mid grey, flag the clamped cases, keep the numerator for division.
  logic                 vb_r;
  logic                 zb_r   [N];
  logic                 sb_r   [N];
  logic [MW-1:0]        mb_r   [N];
  logic signed [PW-1:0] n      [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      n[i] = pa_r[i] + MID_N;
    end
  end

  // Step C: reciprocal multiply and final clamp.
  logic                        vc_r;
  logic [N-1:0][CW-1:0]        chc_r;
  logic [N-1:0][CW-1:0]        chc_nxt;
  logic [MW+RW-1:0]            prod [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      prod[i] = {{RW{1'b0}}, mb_r[i]} * {{MW{1'b0}}, DRECIP};
      if (zb_r[i]) begin
        chc_nxt[i] = '0;
      end else if (sb_r[i]) begin
        chc_nxt[i] = '1;
      end else begin
        chc_nxt[i] = prod[i][DSHIFT+CW-1:DSHIFT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= beat_i.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      pa_r[i] <= pa_nxt[i];
      zb_r[i] <= n[i][PW-1];
      sb_r[i] <= (n[i] >= SAT_N);
      mb_r[i] <= n[i][MW+4:5];
    end
    chc_r <= chc_nxt;
  end

  assign beat_o.valid = vc_r;
  assign beat_o.ch    = chc_r;

endmodule

// ----- hdl/cac_temper.sv -----
// Temperature stage: per-channel offset, division of red and green by a small constant, clamp.
module cac_temper (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cac_pkg::beat_t                        beat_i,
  input  logic signed [cac_pkg::TEMP_W-1:0]     shift_i,
  output logic                                  valid_o,
  output cac_pkg::out_pix_t                     pix_o
);

  localparam int SW = cac_pkg::SAT_W;
  localparam int XW = 14;
  localparam int AW = 13;
  localparam int QW = 10;
  // Reciprocals: 2^15/10 and 2^16/13 rounded up, exact over the numerator range.
  localparam logic [11:0] R10 = 12'd3277;
  localparam int          S10 = 15;
  localparam logic [12:0] R13 = 13'd5042;
  localparam int          S13 = 16;
  localparam logic [5:0]  R18 = 6'd57;
  localparam int          S18 = 10;
  localparam logic [4:0]  BIAS = 5'(cac_pkg::TEMP_BIAS);

  // Offsets that depend on the setting only.
  logic                 neg;
  logic signed [AW-1:0] t13;
  logic signed [AW-1:0] radd;
  logic signed [AW-1:0] gadd;
  logic signed [8:0]    tn;
  logic [12:0]          t18;
  logic [4:0]           badd;

  always_comb begin
    neg  = shift_i[cac_pkg::TEMP_W-1];
    t13  = AW'(shift_i);
    tn   = -(9'(shift_i));
    t18  = {6'b0, shift_i[6:0]} * {7'b0, R18};
    if (neg) begin
      radd = t13 * 13'sd19;
      gadd = t13 * 13'sd10 + 13'sd130;
      badd = BIAS - tn[8:4];
    end else begin
      radd = t13 * 13'sd18 + 13'sd100;
      gadd = t13 * 13'sd13 + 13'sd130;
      badd = BIAS + 5'(t18[12:S18]);
    end
  end

  // Step one: numerators and the blue sum.
  logic                 v1_r;
  logic signed [XW-1:0] xr_r;
  logic signed [XW-1:0] xg_r;
  logic [8:0]           xb_r;

  // Step two: divide, clamp, output register.
  logic                 v2_r;
  cac_pkg::out_pix_t    pix_r;
  cac_pkg::out_pix_t    pix_nxt;
  logic [24:0]          pr;
  logic [25:0]          pg;
  logic [QW-1:0]        qr;
  logic [QW-1:0]        qg;

  always_comb begin
    pr = {12'b0, xr_r[12:0]} * {13'b0, R10};
    pg = {13'b0, xg_r[12:0]} * {13'b0, R13};
    qr = pr[S10+QW-1:S10];
    qg = pg[S13+QW-1:S13];
    pix_nxt.red_out   = xr_r[XW-1] ? '0 : cac_pkg::sat_chan(SW'(qr));
    pix_nxt.green_out = xg_r[XW-1] ? '0 : cac_pkg::sat_chan(SW'(qg));
    pix_nxt.blue_out  = cac_pkg::sat_chan(SW'(xb_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= beat_i.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    xr_r  <= $signed({2'b0, beat_i.ch[cac_pkg::RED], 3'b0})
           + $signed({4'b0, beat_i.ch[cac_pkg::RED], 1'b0}) + XW'(radd);
    xg_r  <= $signed({2'b0, beat_i.ch[cac_pkg::GRN], 3'b0})
           + $signed({3'b0, beat_i.ch[cac_pkg::GRN], 2'b0})
           + $signed({5'b0, beat_i.ch[cac_pkg::GRN]}) + XW'(gadd);
    xb_r  <= {1'b0, beat_i.ch[cac_pkg::BLU]} + {4'b0, badd};
    pix_r <= pix_nxt;
  end

  assign valid_o = v2_r;
  assign pix_o   = pix_r;

endmodule
